// ----- rtl/nkro_pkg.sv -----
// Shared types and constants for the NKRO keyboard report engine.
package nkro_pkg;

   // Key bitmap geometry
   localparam int KEY_COUNT  = 128;
   localparam int KEY_MAP_W  = 128;
   localparam int KEY_IDX_W  = 7;
   localparam int KEY_WORD_W = 64;

   // Modifier codes occupy one aligned block of eight usage codes
   localparam logic [7:0] MOD_FIRST = 8'd224;
   localparam logic [4:0] MOD_BLOCK = MOD_FIRST[7:3];

   // Configuration port geometry
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int TIME_W      = 32;

   localparam logic [CSR_DATA_W-1:0] ENUM_TIMEOUT_RESET  = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] STALL_TIMEOUT_RESET = 16'd500;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENUM_TIMEOUT  = 1'b0,
      CSR_STALL_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_UPDATE      = 3'd0,
      OP_TASK        = 3'd1,
      OP_PRESS       = 3'd2,
      OP_RELEASE     = 3'd3,
      OP_RELEASE_ALL = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      LINK_DISCONNECTED = 2'd0,
      LINK_PENDING      = 2'd1,
      LINK_ACTIVE       = 2'd2,
      LINK_FALLBACK     = 2'd3
   } link_state_type;

   // Link controller to key report: clear request and send completion
   typedef struct packed {
      logic clear_report;
      logic report_sent;
   } link_ctl_type;

endpackage

// ----- rtl/nkro_link.sv -----
// Link state machine with enumeration and stall timeouts.
module nkro_link (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [2:0]                          opcode,
   input  logic                                mounted,
   input  logic                                endpoint_ready,
   input  logic                                send_accepted,
   input  logic [nkro_pkg::TIME_W-1:0]         now_ms,
   input  logic [nkro_pkg::CSR_DATA_W-1:0]     enum_timeout_ms,
   input  logic [nkro_pkg::CSR_DATA_W-1:0]     stall_timeout_ms,
   input  logic                                changed_flag,
   output nkro_pkg::link_state_type            link_state_in,
   output nkro_pkg::link_ctl_type              link_ctl
);
   import nkro_pkg::*;

   link_state_type      state_ff;
   link_state_type      state_in;
   logic [TIME_W-1:0]   mount_time_ff;
   logic [TIME_W-1:0]   mount_time_in;
   logic [TIME_W-1:0]   progress_time_ff;
   logic [TIME_W-1:0]   progress_time_in;
   logic [TIME_W-1:0]   mount_age;
   logic [TIME_W-1:0]   progress_age;
   logic                is_update;
   logic                is_task;
   logic                clear_report;
   logic                report_sent;

   assign is_update = (opcode == OP_UPDATE) || (opcode == OP_TASK);
   assign is_task   = (opcode == OP_TASK);

   // Elapsed times, wrapping modulo 2^32
   assign mount_age    = now_ms - mount_time_ff;
   assign progress_age = now_ms - progress_time_ff;

   // Next state, timestamps and report control
   always_comb begin
      state_in         = state_ff;
      mount_time_in    = mount_time_ff;
      progress_time_in = progress_time_ff;
      clear_report     = 1'b0;
      report_sent      = 1'b0;
      if (is_update) begin
         if (!mounted) begin
            state_in         = LINK_DISCONNECTED;
            mount_time_in    = '0;
            progress_time_in = '0;
            clear_report     = 1'b1;
         end else begin
            unique case (state_ff)
               LINK_DISCONNECTED: begin
                  // Fresh mount: the age is zero, so only a zero timeout expires
                  mount_time_in    = now_ms;
                  progress_time_in = now_ms;
                  clear_report     = 1'b1;
                  if (endpoint_ready) begin
                     state_in = LINK_ACTIVE;
                  end else if (enum_timeout_ms == '0) begin
                     state_in = LINK_FALLBACK;
                  end else begin
                     state_in = LINK_PENDING;
                  end
               end
               LINK_PENDING: begin
                  if (endpoint_ready) begin
                     state_in         = LINK_ACTIVE;
                     progress_time_in = now_ms;
                  end else if (mount_age >= TIME_W'(enum_timeout_ms)) begin
                     state_in     = LINK_FALLBACK;
                     clear_report = 1'b1;
                  end
               end
               LINK_ACTIVE: begin
                  if (endpoint_ready) begin
                     progress_time_in = now_ms;
                  end else if (progress_age >= TIME_W'(stall_timeout_ms)) begin
                     state_in     = LINK_FALLBACK;
                     clear_report = 1'b1;
                  end
               end
               LINK_FALLBACK: begin
                  state_in = LINK_FALLBACK;
               end
               default: begin
                  state_in = state_ff;
               end
            endcase
            // Hand over a changed report once the link is up
            if (is_task && (state_in == LINK_ACTIVE) && changed_flag && !clear_report &&
                endpoint_ready && send_accepted) begin
               report_sent      = 1'b1;
               progress_time_in = now_ms;
            end
         end
      end
   end

   // Advance state only when an item completes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= LINK_DISCONNECTED;
         mount_time_ff    <= '0;
         progress_time_ff <= '0;
      end else if (step) begin
         state_ff         <= state_in;
         mount_time_ff    <= mount_time_in;
         progress_time_ff <= progress_time_in;
      end
   end

   assign link_state_in         = state_in;
   assign link_ctl.clear_report = clear_report;
   assign link_ctl.report_sent  = report_sent;

endmodule

// ----- rtl/nkro_keys.sv -----
// Key bitmap, modifier byte and changed flag.
module nkro_keys (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [2:0]                          opcode,
   input  logic [7:0]                          keycode,
   input  nkro_pkg::link_ctl_type              link_ctl,
   output logic                                changed_flag,
   output logic [7:0]                          modifier_in,
   output logic [nkro_pkg::KEY_MAP_W-1:0]      key_map_in,
   output logic                                changed_in
);
   import nkro_pkg::*;

   logic [KEY_MAP_W-1:0]  key_map_ff;
   logic [7:0]            modifier_ff;
   logic                  changed_ff;
   logic                  press;
   logic                  is_mod;
   logic                  is_key;
   logic [2:0]            mod_idx;
   logic [KEY_IDX_W-1:0]  key_idx;

   assign press   = (opcode == OP_PRESS);
   assign is_mod  = (keycode[7:3] == MOD_BLOCK);
   assign is_key  = (keycode != 8'd0) && (keycode < 8'(KEY_COUNT));
   assign mod_idx = keycode[2:0];
   assign key_idx = keycode[KEY_IDX_W-1:0];

   // Apply one operation to the report
   always_comb begin
      key_map_in  = key_map_ff;
      modifier_in = modifier_ff;
      changed_in  = changed_ff;
      unique case (opcode)
         OP_UPDATE, OP_TASK: begin
            if (link_ctl.clear_report) begin
               key_map_in  = '0;
               modifier_in = '0;
               changed_in  = 1'b0;
            end
            if (link_ctl.report_sent) begin
               changed_in = 1'b0;
            end
         end
         OP_PRESS, OP_RELEASE: begin
            if (is_mod) begin
               modifier_in[mod_idx] = press;
               if (modifier_ff[mod_idx] != press) begin
                  changed_in = 1'b1;
               end
            end else if (is_key) begin
               key_map_in[key_idx] = press;
               if (key_map_ff[key_idx] != press) begin
                  changed_in = 1'b1;
               end
            end
         end
         OP_RELEASE_ALL: begin
            key_map_in  = '0;
            modifier_in = '0;
            changed_in  = 1'b1;
         end
         default: begin
            changed_in = changed_ff;
         end
      endcase
   end

   // Hold the report between items
   always_ff @(posedge clock) begin
      if (reset) begin
         key_map_ff  <= '0;
         modifier_ff <= '0;
         changed_ff  <= 1'b0;
      end else if (step) begin
         key_map_ff  <= key_map_in;
         modifier_ff <= modifier_in;
         changed_ff  <= changed_in;
      end
   end

   assign changed_flag = changed_ff;

endmodule

// ----- rtl/nkro_keyboard_report_engine.sv -----
// Top level of the NKRO keyboard report engine: input register, result register, CSRs.
//
// One result per operation, one operation per clock when the result side keeps up.
// An accepted item sits in an input register; in the cycle it moves on, the link state
// machine and key report update in one pass and the result register captures the new
// report, which raises rsp_valid; an item moves on only when the result register is free.
// req_ready stays high while the result register is empty or being taken, so a full
// stream moves at one item per cycle; the input register absorbs one item while a result
// waits. Timeout registers are written through csr_write while no item is in flight;
// the user must keep to this, since the block itself does not enforce it.
module nkro_keyboard_report_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_opcode,
   input  logic [7:0]                          req_keycode,
   input  logic                                req_mounted,
   input  logic                                req_endpoint_ready,
   input  logic                                req_send_accepted,
   input  logic [nkro_pkg::TIME_W-1:0]         req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_link_state,
   output logic                                rsp_report_sent,
   output logic [7:0]                          rsp_modifier_out,
   output logic [nkro_pkg::KEY_WORD_W-1:0]     rsp_keys_low,
   output logic [nkro_pkg::KEY_WORD_W-1:0]     rsp_keys_high,
   output logic                                rsp_pending_change,
   input  logic                                csr_write,
   input  logic [nkro_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nkro_pkg::CSR_DATA_W-1:0]     csr_data
);
   import nkro_pkg::*;

   logic [CSR_DATA_W-1:0]  enum_timeout_ff;
   logic [CSR_DATA_W-1:0]  stall_timeout_ff;

   logic                   s1_valid_ff;
   logic [2:0]             s1_opcode_ff;
   logic [7:0]             s1_keycode_ff;
   logic                   s1_mounted_ff;
   logic                   s1_ready_ff;
   logic                   s1_accepted_ff;
   logic [TIME_W-1:0]      s1_now_ff;
   logic                   s1_advance;
   logic                   req_take;

   link_state_type         link_state_in;
   link_ctl_type           link_ctl;
   logic                   changed_flag;
   logic [7:0]             modifier_in;
   logic [KEY_MAP_W-1:0]   key_map_in;
   logic                   changed_in;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_state_ff;
   logic                   rsp_sent_ff;
   logic [7:0]             rsp_mod_ff;
   logic [KEY_MAP_W-1:0]   rsp_keys_ff;
   logic                   rsp_change_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enum_timeout_ff  <= ENUM_TIMEOUT_RESET;
         stall_timeout_ff <= STALL_TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ENUM_TIMEOUT:  enum_timeout_ff  <= csr_data;
            CSR_STALL_TIMEOUT: stall_timeout_ff <= csr_data;
            default:           enum_timeout_ff  <= enum_timeout_ff;
         endcase
      end
   end

   // Handshake: advance the input stage when the result register frees up
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff   <= req_opcode;
         s1_keycode_ff  <= req_keycode;
         s1_mounted_ff  <= req_mounted;
         s1_ready_ff    <= req_endpoint_ready;
         s1_accepted_ff <= req_send_accepted;
         s1_now_ff      <= req_now_ms;
      end
   end

   nkro_link u_link (
      .clock            (clock),
      .reset            (reset),
      .step             (s1_advance),
      .opcode           (s1_opcode_ff),
      .mounted          (s1_mounted_ff),
      .endpoint_ready   (s1_ready_ff),
      .send_accepted    (s1_accepted_ff),
      .now_ms           (s1_now_ff),
      .enum_timeout_ms  (enum_timeout_ff),
      .stall_timeout_ms (stall_timeout_ff),
      .changed_flag     (changed_flag),
      .link_state_in    (link_state_in),
      .link_ctl         (link_ctl)
   );

   nkro_keys u_keys (
      .clock        (clock),
      .reset        (reset),
      .step         (s1_advance),
      .opcode       (s1_opcode_ff),
      .keycode      (s1_keycode_ff),
      .link_ctl     (link_ctl),
      .changed_flag (changed_flag),
      .modifier_in  (modifier_in),
      .key_map_in   (key_map_in),
      .changed_in   (changed_in)
   );

   // Result register: load on advance, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_state_ff  <= link_state_in;
         rsp_sent_ff   <= link_ctl.report_sent;
         rsp_mod_ff    <= modifier_in;
         rsp_keys_ff   <= key_map_in;
         rsp_change_ff <= changed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_link_state     = rsp_state_ff;
   assign rsp_report_sent    = rsp_sent_ff;
   assign rsp_modifier_out   = rsp_mod_ff;
   assign rsp_keys_low       = rsp_keys_ff[KEY_WORD_W-1:0];
   assign rsp_keys_high      = rsp_keys_ff[KEY_MAP_W-1:KEY_WORD_W];
   assign rsp_pending_change = rsp_change_ff;

   // A sent report leaves the link active with nothing left to send
   a_sent_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_sent |->
         (rsp_link_state == LINK_ACTIVE) && !rsp_pending_change)
      else $error("report sent outside active link or with change still pending");

   // A held item in the input stage is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff)
      else $error("input stage lost an item");

   // An empty result register never blocks the input side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

// ----- tb/nkro_report_checker.sv -----
// Scoreboard for the NKRO report engine: predicts each report and compares it on transfer.
module nkro_report_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [2:0]                       req_opcode,
   input  logic [7:0]                       req_keycode,
   input  logic                             req_mounted,
   input  logic                             req_endpoint_ready,
   input  logic                             req_send_accepted,
   input  logic [nkro_pkg::TIME_W-1:0]      req_now_ms,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [1:0]                       rsp_link_state,
   input  logic                             rsp_report_sent,
   input  logic [7:0]                       rsp_modifier_out,
   input  logic [nkro_pkg::KEY_WORD_W-1:0]  rsp_keys_low,
   input  logic [nkro_pkg::KEY_WORD_W-1:0]  rsp_keys_high,
   input  logic                             rsp_pending_change,
   input  logic                             csr_write,
   input  logic [nkro_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nkro_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               fail_count,
   output int                               reports_waiting,
   output int                               reports_checked,
   output int                               reports_sent
);
   import nkro_pkg::*;

   typedef struct packed {
      logic [2:0]        opcode;
      logic [7:0]        keycode;
      logic              mounted;
      logic              endpoint_ready;
      logic              send_accepted;
      logic [TIME_W-1:0] now_ms;
   } key_event_type;

   typedef struct packed {
      link_state_type        link;
      logic                  sent;
      logic [7:0]            modifiers;
      logic [KEY_WORD_W-1:0] keys_low;
      logic [KEY_WORD_W-1:0] keys_high;
      logic                  dirty;
   } hid_report_type;

   // Shadow copy of the engine state and its timeout registers
   logic [KEY_MAP_W-1:0]  key_bits;
   logic [7:0]            mod_bits;
   logic                  dirty;
   link_state_type        link;
   logic [TIME_W-1:0]     mount_ms;
   logic [TIME_W-1:0]     progress_ms;
   logic [CSR_DATA_W-1:0] enum_limit;
   logic [CSR_DATA_W-1:0] stall_limit;

   hid_report_type expected_reports[$];
   int             errors;
   int             checked;
   int             sends;

   assign fail_count      = errors;
   assign reports_checked = checked;
   assign reports_sent    = sends;

   task automatic clear_report();
      key_bits = '0;
      mod_bits = '0;
      dirty    = 1'b0;
   endtask

   // Set or clear one key or modifier; flag a change only when a bit flips
   task automatic change_key(input logic [7:0] code, input logic press);
      if (code >= MOD_FIRST && code <= MOD_FIRST + 8'd7) begin
         if (mod_bits[code[2:0]] != press) begin
            mod_bits[code[2:0]] = press;
            dirty = 1'b1;
         end
      end else if (code != 8'd0 && code < KEY_COUNT) begin
         if (key_bits[code[KEY_IDX_W-1:0]] != press) begin
            key_bits[code[KEY_IDX_W-1:0]] = press;
            dirty = 1'b1;
         end
      end
   endtask

   // Advance the shadow state by one operation and form the report it yields
   task automatic compute_report(input key_event_type ev, output hid_report_type rpt);
      logic sent;
      sent = 1'b0;
      case (ev.opcode)
         OP_UPDATE, OP_TASK: begin
            if (!ev.mounted) begin
               link        = LINK_DISCONNECTED;
               mount_ms    = '0;
               progress_ms = '0;
               clear_report();
            end else begin
               if (link == LINK_DISCONNECTED) begin
                  link        = LINK_PENDING;
                  mount_ms    = ev.now_ms;
                  progress_ms = ev.now_ms;
                  clear_report();
               end
               if (link == LINK_PENDING) begin
                  if (ev.endpoint_ready) begin
                     link        = LINK_ACTIVE;
                     progress_ms = ev.now_ms;
                  end else if (TIME_W'(ev.now_ms - mount_ms) >= TIME_W'(enum_limit)) begin
                     link = LINK_FALLBACK;
                     clear_report();
                  end
               end
               if (link == LINK_ACTIVE) begin
                  if (ev.endpoint_ready) begin
                     progress_ms = ev.now_ms;
                  end else if (TIME_W'(ev.now_ms - progress_ms) >= TIME_W'(stall_limit)) begin
                     link = LINK_FALLBACK;
                     clear_report();
                  end
               end
            end
            // Hand the report over only on a fully ready, accepted send
            if (ev.opcode == OP_TASK && link == LINK_ACTIVE && dirty && ev.mounted &&
                ev.endpoint_ready && ev.send_accepted) begin
               dirty       = 1'b0;
               progress_ms = ev.now_ms;
               sent        = 1'b1;
            end
         end
         OP_PRESS:   change_key(ev.keycode, 1'b1);
         OP_RELEASE: change_key(ev.keycode, 1'b0);
         OP_RELEASE_ALL: begin
            key_bits = '0;
            mod_bits = '0;
            dirty    = 1'b1;
         end
         default: ;
      endcase
      rpt.link      = link;
      rpt.sent      = sent;
      rpt.modifiers = mod_bits;
      rpt.keys_low  = key_bits[KEY_WORD_W-1:0];
      rpt.keys_high = key_bits[KEY_MAP_W-1:KEY_WORD_W];
      rpt.dirty     = dirty;
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Compare result transfers, predict request transfers, track register writes
   always @(posedge clock) begin
      key_event_type  ev;
      hid_report_type rpt;
      if (reset) begin
         clear_report();
         link        = LINK_DISCONNECTED;
         mount_ms    = '0;
         progress_ms = '0;
         enum_limit  = ENUM_TIMEOUT_RESET;
         stall_limit = STALL_TIMEOUT_RESET;
         expected_reports.delete();
         errors  = 0;
         checked = 0;
         sends   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: report with none expected: actual state %h sent %b", $time,
                        rsp_link_state, rsp_report_sent);
               errors++;
            end else begin
               rpt = expected_reports.pop_front();
               check_field("link_state", rpt.link, rsp_link_state);
               check_field("report_sent", rpt.sent, rsp_report_sent);
               check_field("modifier_out", rpt.modifiers, rsp_modifier_out);
               check_field("keys_low", rpt.keys_low, rsp_keys_low);
               check_field("keys_high", rpt.keys_high, rsp_keys_high);
               check_field("pending_change", rpt.dirty, rsp_pending_change);
               checked++;
               if (rsp_report_sent) sends++;
            end
         end
         if (req_valid && req_ready) begin
            ev = '{req_opcode, req_keycode, req_mounted, req_endpoint_ready,
                   req_send_accepted, req_now_ms};
            compute_report(ev, rpt);
            expected_reports.push_back(rpt);
         end
         if (csr_write) begin
            if (csr_index == CSR_ENUM_TIMEOUT) enum_limit = csr_data;
            else if (csr_index == CSR_STALL_TIMEOUT) stall_limit = csr_data;
         end
      end
      reports_waiting <= expected_reports.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// Top of the NKRO report engine testbench: clock, reset, stimulus, handshake pacing, verdict.
module tb_top;
   import nkro_pkg::*;

   localparam int          WATCHDOG_LIMIT    = 2000;
   localparam int          SEGMENTS          = 8;
   localparam int          OPS_PER_SEGMENT   = 225;
   localparam logic [2:0]  OP_RESERVED_FIRST = 3'd5;
   localparam logic [2:0]  OP_RESERVED_LAST  = 3'd7;

   logic                   clock;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_ready;
   logic [2:0]             req_opcode         = OP_UPDATE;
   logic [7:0]             req_keycode        = '0;
   logic                   req_mounted        = 1'b0;
   logic                   req_endpoint_ready = 1'b0;
   logic                   req_send_accepted  = 1'b0;
   logic [TIME_W-1:0]      req_now_ms         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready          = 1'b0;
   logic [1:0]             rsp_link_state;
   logic                   rsp_report_sent;
   logic [7:0]             rsp_modifier_out;
   logic [KEY_WORD_W-1:0]  rsp_keys_low;
   logic [KEY_WORD_W-1:0]  rsp_keys_high;
   logic                   rsp_pending_change;
   logic                   csr_write          = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = CSR_ENUM_TIMEOUT;
   logic [CSR_DATA_W-1:0]  csr_data           = '0;

   int                     fail_count;
   int                     reports_waiting;
   int                     reports_checked;
   int                     reports_sent;
   int                     send_idle_pct      = 0;
   int                     rsp_stall_pct      = 0;
   int                     quiet_cycles       = 0;
   int                     ops_sent           = 0;
   logic [TIME_W-1:0]      clock_ms;

   nkro_keyboard_report_engine i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_keycode        (req_keycode),
      .req_mounted        (req_mounted),
      .req_endpoint_ready (req_endpoint_ready),
      .req_send_accepted  (req_send_accepted),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_link_state     (rsp_link_state),
      .rsp_report_sent    (rsp_report_sent),
      .rsp_modifier_out   (rsp_modifier_out),
      .rsp_keys_low       (rsp_keys_low),
      .rsp_keys_high      (rsp_keys_high),
      .rsp_pending_change (rsp_pending_change),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   nkro_report_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_keycode        (req_keycode),
      .req_mounted        (req_mounted),
      .req_endpoint_ready (req_endpoint_ready),
      .req_send_accepted  (req_send_accepted),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_link_state     (rsp_link_state),
      .rsp_report_sent    (rsp_report_sent),
      .rsp_modifier_out   (rsp_modifier_out),
      .rsp_keys_low       (rsp_keys_low),
      .rsp_keys_high      (rsp_keys_high),
      .rsp_pending_change (rsp_pending_change),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .reports_waiting    (reports_waiting),
      .reports_checked    (reports_checked),
      .reports_sent       (reports_sent)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result side at the current phase rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Stop the run when no transfer has happened for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d reports outstanding", $time,
                  reports_waiting);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one operation after a random idle gap and hold it until transfer
   task automatic send_op(input logic [2:0] op, input logic [7:0] key, input logic mnt,
                          input logic rdy, input logic acc, input logic [TIME_W-1:0] ms);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_keycode        <= key;
      req_mounted        <= mnt;
      req_endpoint_ready <= rdy;
      req_send_accepted  <= acc;
      req_now_ms         <= ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ops_sent++;
   endtask

   // Hold off new requests until every predicted report has arrived
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (reports_waiting != 0);
   endtask

   task automatic program_timeouts(input logic [CSR_DATA_W-1:0] enum_ms,
                                   input logic [CSR_DATA_W-1:0] stall_ms);
      csr_write <= 1'b1;
      csr_index <= CSR_ENUM_TIMEOUT;
      csr_data  <= enum_ms;
      @(posedge clock);
      csr_index <= CSR_STALL_TIMEOUT;
      csr_data  <= stall_ms;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Mostly mounted, ready traffic with key churn; some drops and odd codes
   task automatic send_random_op();
      int          pick;
      logic [2:0]  op;
      logic [7:0]  key;
      pick = $urandom_range(0, 99);
      if (pick < 35)      op = OP_PRESS;
      else if (pick < 60) op = OP_RELEASE;
      else if (pick < 82) op = OP_TASK;
      else if (pick < 93) op = OP_UPDATE;
      else if (pick < 97) op = OP_RELEASE_ALL;
      else                op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
      pick = $urandom_range(0, 99);
      if (pick < 50)      key = 8'($urandom_range(0, KEY_COUNT - 1));
      else if (pick < 75) key = MOD_FIRST + 8'($urandom_range(0, 7));
      else if (pick < 90) key = 8'($urandom_range(4, 11));
      else                key = 8'($urandom_range(0, 255));
      // Advance time mostly in small steps, sometimes past any timeout or anywhere
      pick = $urandom_range(0, 99);
      if (pick < 70)      clock_ms = clock_ms + $urandom_range(0, 20);
      else if (pick < 90) clock_ms = clock_ms + $urandom_range(0, 600);
      else if (pick < 97) clock_ms = clock_ms + $urandom_range(0, 70000);
      else                clock_ms = $urandom;
      send_op(op, key, $urandom_range(0, 99) < 96, $urandom_range(0, 99) < 75,
              $urandom_range(0, 99) < 75, clock_ms);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] enum_plan  [SEGMENTS];
      logic [CSR_DATA_W-1:0] stall_plan [SEGMENTS];
      logic [TIME_W-1:0]     t0;
      logic [TIME_W-1:0]     t1;
      enum_plan  = '{16'd0, 16'hFFFF, 16'd20, 16'd3, 16'd500, 16'hFFFF, 16'd0, 16'd0};
      stall_plan = '{16'd0, 16'hFFFF, 16'd15, 16'd200, 16'd5, 16'd0, 16'hFFFF, 16'd0};
      enum_plan[SEGMENTS-1]  = 16'($urandom_range(0, 65535));
      stall_plan[SEGMENTS-1] = 16'($urandom_range(0, 65535));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset timeouts, enumeration timeout across the time wrap
      t0 = 32'hFFFF_FF00;
      send_op(OP_UPDATE, 8'd0, 1'b0, 1'b0, 1'b0, 32'd7);
      send_op(OP_PRESS, 8'd4, 1'b0, 1'b0, 1'b0, 32'd8);
      send_op(OP_UPDATE, 8'd0, 1'b1, 1'b0, 1'b0, t0);
      send_op(OP_UPDATE, 8'd0, 1'b1, 1'b0, 1'b0, t0 + 32'd999);
      send_op(OP_UPDATE, 8'd0, 1'b1, 1'b0, 1'b0, t0 + 32'd1000);
      send_op(OP_TASK, 8'd0, 1'b1, 1'b1, 1'b1, t0 + 32'd1001);
      send_op(OP_UPDATE, 8'd0, 1'b0, 1'b1, 1'b1, t0 + 32'd1002);
      // Enter active, then hit every key class including ignored codes
      t1 = 32'd100;
      send_op(OP_UPDATE, 8'd0, 1'b1, 1'b1, 1'b0, t1);
      send_op(OP_PRESS, 8'd0, 1'b1, 1'b1, 1'b0, t1);
      send_op(OP_PRESS, 8'd1, 1'b1, 1'b1, 1'b0, t1);
      send_op(OP_PRESS, 8'd63, 1'b1, 1'b1, 1'b0, t1);
      send_op(OP_PRESS, 8'd64, 1'b1, 1'b1, 1'b0, t1);
      send_op(OP_PRESS, 8'd127, 1'b1, 1'b1, 1'b0, t1);
      send_op(OP_PRESS, 8'd128, 1'b1, 1'b1, 1'b0, t1);
      send_op(OP_PRESS, MOD_FIRST, 1'b1, 1'b1, 1'b0, t1);
      send_op(OP_PRESS, MOD_FIRST + 8'd7, 1'b1, 1'b1, 1'b0, t1);
      send_op(OP_PRESS, 8'd255, 1'b1, 1'b1, 1'b0, t1);
      // Send; a repeat press and untouched release keep the flag clear, held releases set it
      send_op(OP_TASK, 8'd0, 1'b1, 1'b1, 1'b1, t1 + 32'd10);
      send_op(OP_PRESS, 8'd127, 1'b1, 1'b1, 1'b0, t1 + 32'd10);
      send_op(OP_RELEASE, 8'd2, 1'b1, 1'b1, 1'b0, t1 + 32'd10);
      send_op(OP_RELEASE, 8'd127, 1'b1, 1'b1, 1'b0, t1 + 32'd10);
      send_op(OP_RELEASE, MOD_FIRST + 8'd7, 1'b1, 1'b1, 1'b0, t1 + 32'd10);
      // Refused and not-ready sends, reserved opcodes, release all, stall short of the timeout
      send_op(OP_TASK, 8'd0, 1'b1, 1'b1, 1'b0, t1 + 32'd15);
      send_op(OP_TASK, 8'd0, 1'b1, 1'b0, 1'b1, t1 + 32'd20);
      for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
         send_op(3'(op), 8'd5, 1'b0, 1'b0, 1'b0, 32'd0);
      send_op(OP_RELEASE_ALL, 8'd0, 1'b1, 1'b0, 1'b0, t1 + 32'd20);
      send_op(OP_UPDATE, 8'd0, 1'b1, 1'b0, 1'b0, t1 + 32'd510);

      // Random segments: each pair of segments shares one idling phase
      clock_ms = $urandom;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_for_results();
         program_timeouts(enum_plan[seg], stall_plan[seg]);
         case (seg / 2)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 57; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 57; end
            default: begin send_idle_pct = 16; rsp_stall_pct <= 16; end
         endcase
         repeat (OPS_PER_SEGMENT) begin
            if ($urandom_range(0, 199) == 0) wait_for_results();
            send_random_op();
         end
      end

      wait_for_results();
      repeat (4) @(posedge clock);
      $display("Run covered %0d operations over four pacing phases and %0d timeout settings;",
               ops_sent, SEGMENTS + 1);
      $display("%0d reports compared, %0d of them handed over to the host", reports_checked,
               reports_sent);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
